// ===== src/mpq_pkg.sv =====
package mpq_pkg;

    localparam int CAPACITY = 64;
    localparam int OCC_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_PEEK   = 2'd1,
        OP_POP    = 2'd2,
        OP_LOAD   = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] min_value;
        logic               is_empty;
        logic               overflow;
    } t_out;

    typedef struct packed {
        logic do_insert;
        logic do_pop;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_status;

endpackage

// ===== src/mpq_datapath.sv =====
module mpq_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mpq_pkg::t_cmd        i_cmd,
    input  logic signed [31:0]   i_value,
    output mpq_pkg::t_status     o_status,
    output logic signed [31:0]   o_min
);

    logic signed [31:0] r_cell [mpq_pkg::CAPACITY];
    logic signed [31:0] n_cell [mpq_pkg::CAPACITY];
    logic [mpq_pkg::OCC_W-1:0] r_occ;
    logic [mpq_pkg::OCC_W-1:0] n_occ;

    // systolic sorted array: each cell looks at itself and its neighbor
    always_comb begin
        for (int k = 0; k < mpq_pkg::CAPACITY; k++) begin
            logic occ_k;
            logic occ_p;
            logic gt_k;
            logic gt_p;
            occ_k = (mpq_pkg::OCC_W'(k) < r_occ);
            occ_p = (k > 0) && (mpq_pkg::OCC_W'(k - 1) < r_occ);
            gt_k  = occ_k && (r_cell[k] > i_value);
            gt_p  = (k > 0) && occ_p && (r_cell[(k > 0) ? k - 1 : 0] > i_value);
            n_cell[k] = r_cell[k];
            if (i_cmd.do_insert) begin
                if (gt_p) begin
                    n_cell[k] = r_cell[(k > 0) ? k - 1 : 0];
                end else if (gt_k || !occ_k) begin
                    n_cell[k] = i_value;
                end
            end else if (i_cmd.do_pop) begin
                if (k < mpq_pkg::CAPACITY - 1) begin
                    n_cell[k] = r_cell[(k < mpq_pkg::CAPACITY - 1) ? k + 1 : k];
                end
            end
        end
    end

    always_comb begin
        n_occ = r_occ;
        if (i_cmd.do_insert) begin
            n_occ = r_occ + 1'b1;
        end else if (i_cmd.do_pop) begin
            n_occ = r_occ - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < mpq_pkg::CAPACITY; k++) begin
            r_cell[k] <= n_cell[k];
        end
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign o_status.full  = (r_occ == mpq_pkg::OCC_W'(mpq_pkg::CAPACITY));
    assign o_status.empty = (r_occ == '0);
    assign o_min          = o_status.empty ? 32'sd0 : r_cell[0];

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= mpq_pkg::OCC_W'(mpq_pkg::CAPACITY))
        else $error("occupancy beyond capacity");
    a_ins_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_insert |-> !o_status.full)
        else $error("insert into full array");
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_pop |-> !o_status.empty)
        else $error("pop from empty array");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.do_insert && i_cmd.do_pop))
        else $error("insert and pop together");

endmodule

// ===== src/mpq_ctrl.sv =====
module mpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mpq_pkg::t_in       i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mpq_pkg::t_out      o_out,
    output mpq_pkg::t_cmd      o_cmd,
    input  mpq_pkg::t_status   i_status,
    input  logic signed [31:0] i_min
);

    typedef enum logic [1:0] {
        S_ACCEPT = 2'b01,
        S_REPORT = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_rep, n_rep;
    logic   r_drop, n_drop;
    logic   r_ovalid, n_ovalid;
    mpq_pkg::t_out r_out, n_out;
    logic   acc;

    assign o_in_ready  = (r_state == S_ACCEPT);
    assign acc         = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    always_comb begin
        o_cmd.do_insert = acc && !i_status.full &&
            (i_in.op == mpq_pkg::OP_INSERT || i_in.op == mpq_pkg::OP_LOAD);
        o_cmd.do_pop = acc && !i_status.empty && (i_in.op == mpq_pkg::OP_POP);
    end

    always_comb begin
        n_state  = r_state;
        n_rep    = r_rep;
        n_drop   = r_drop;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_ACCEPT: begin
                if (acc) begin
                    n_drop  = i_status.full &&
                        (i_in.op == mpq_pkg::OP_INSERT || i_in.op == mpq_pkg::OP_LOAD);
                    n_rep   = (i_in.op != mpq_pkg::OP_LOAD) || n_drop;
                    n_state = S_REPORT;
                end
            end
            S_REPORT: begin
                if (!r_rep) begin
                    n_state = S_ACCEPT;
                end else if (!r_ovalid || i_out_ready) begin
                    n_ovalid        = 1'b1;
                    n_out.min_value = i_min;
                    n_out.is_empty  = i_status.empty;
                    n_out.overflow  = r_drop;
                    n_state         = S_ACCEPT;
                end
            end
            default: n_state = S_ACCEPT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_rep  <= n_rep;
        r_drop <= n_drop;
        if (!i_rst_n) begin
            r_state  <= S_ACCEPT;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_out_ready |=> r_ovalid && $stable(r_out))
        else $error("result lost under stall");
    a_alt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_state == S_REPORT)
        else $error("missing report state");
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.overflow |-> !r_out.is_empty)
        else $error("overflow on empty");

endmodule

// ===== src/min_priority_queue.sv =====
// channel | valid      | ready      | payload
// in      | i_in_valid | o_in_ready | i_in  (mpq_pkg::t_in)
// out     | o_out_valid| i_out_ready| o_out (mpq_pkg::t_out)
// Each transaction is accepted, then reported from the updated sorted array (LOAD reports only if dropped).
// Insert/pop updates the systolic array in the accept cycle.
// Sync active-low reset empties the queue; cell contents are not cleared.
// A stalled output holds the report state and blocks new input.
module min_priority_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mpq_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mpq_pkg::t_out o_out
);

    mpq_pkg::t_cmd      w_cmd;
    mpq_pkg::t_status   w_status;
    logic signed [31:0] w_min;

    mpq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .o_cmd(w_cmd), .i_status(w_status), .i_min(w_min)
    );

    mpq_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .i_value(i_in.value),
        .o_status(w_status), .o_min(w_min)
    );

endmodule

// ===== bench/min_priority_queue_check.sv =====
`timescale 1ns / 100ps

module min_priority_queue_check (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  mpq_pkg::t_in  i_in,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  mpq_pkg::t_out i_out,
    output int            o_errors,
    output int            o_pending
);

    logic signed [31:0] sorted_vals [mpq_pkg::CAPACITY];
    int                 stored;
    mpq_pkg::t_out      report_q [$];

    function automatic mpq_pkg::t_out min_report(input logic dropped);
        mpq_pkg::t_out r;
        r.min_value = (stored == 0) ? 32'sd0 : sorted_vals[0];
        r.is_empty  = (stored == 0);
        r.overflow  = dropped;
        return r;
    endfunction

    function automatic logic add_value(input logic signed [31:0] v);
        int i;
        if (stored >= mpq_pkg::CAPACITY) return 1'b0;
        i = stored;
        while (i > 0 && sorted_vals[i-1] > v) begin
            sorted_vals[i] = sorted_vals[i-1];
            i--;
        end
        sorted_vals[i] = v;
        stored++;
        return 1'b1;
    endfunction

    task automatic apply_op(input mpq_pkg::t_in t);
        logic ok;
        case (mpq_pkg::t_op'(t.op))
            mpq_pkg::OP_INSERT: begin
                ok = add_value(t.value);
                report_q.push_back(min_report(!ok));
            end
            mpq_pkg::OP_PEEK: report_q.push_back(min_report(1'b0));
            mpq_pkg::OP_POP: begin
                if (stored > 0) begin
                    for (int i = 1; i < stored; i++) sorted_vals[i-1] = sorted_vals[i];
                    stored--;
                end
                report_q.push_back(min_report(1'b0));
            end
            default: begin
                ok = add_value(t.value);
                if (!ok) report_q.push_back(min_report(1'b1));
            end
        endcase
    endtask

    initial begin
        o_errors = 0;
        stored   = 0;
    end

    assign o_pending = report_q.size();

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (report_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("unexpected result %p", i_out);
                end else begin
                    if (report_q[0] !== i_out) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("mismatch: expected %p actual %p", report_q[0], i_out);
                    end
                    void'(report_q.pop_front());
                end
            end
            if (i_in_valid && i_in_ready) apply_op(i_in);
        end
    end
endmodule

// ===== bench/min_priority_queue_test.sv =====
`timescale 1ns / 100ps

module min_priority_queue_test;

    localparam int IDLE_LIMIT = 5000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    mpq_pkg::t_in  i_in;
    logic          o_out_valid;
    logic          i_out_ready;
    mpq_pkg::t_out o_out;
    int            errors;
    int            pending;
    int            idle_cycles;
    int            stall_mode;

    min_priority_queue uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    min_priority_queue_check checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in(i_in),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out(o_out),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_ready = 1'b0;
        stall_mode  = 0;
    end

    // receiver: phases of always-ready, random, and long stalls
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 2) != 0);
            default: i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send(input mpq_pkg::t_op op, input logic signed [31:0] v);
        i_in_valid <= 1'b1;
        i_in.op    <= op;
        i_in.value <= v;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic gap();
        i_in_valid <= 1'b0;
        i_in       <= '0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_value(input int narrow);
        case ($urandom_range(0, 5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return $urandom;
            default: return $signed($urandom_range(0, 2 * narrow)) - narrow;
        endcase
    endfunction

    initial begin
        int burst;
        int fill_bias;
        idle_cycles = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(mpq_pkg::OP_PEEK, 32'sd5);
        send(mpq_pkg::OP_POP, -32'sd1);
        send(mpq_pkg::OP_INSERT, 32'sh7fff_ffff);
        send(mpq_pkg::OP_INSERT, 32'sh8000_0000);
        send(mpq_pkg::OP_INSERT, 32'sd0);
        send(mpq_pkg::OP_INSERT, 32'sd0);
        send(mpq_pkg::OP_LOAD, -32'sd1);
        send(mpq_pkg::OP_PEEK, 32'sd0);
        repeat (6) send(mpq_pkg::OP_POP, 32'sd0);
        for (int i = 0; i < mpq_pkg::CAPACITY; i++) send(mpq_pkg::OP_LOAD, $urandom);
        send(mpq_pkg::OP_LOAD, 32'sd1);
        send(mpq_pkg::OP_INSERT, 32'sh8000_0000);
        send(mpq_pkg::OP_PEEK, 32'sd0);
        repeat (mpq_pkg::CAPACITY + 1) send(mpq_pkg::OP_POP, 32'sd0);

        fill_bias = 50;
        for (int n = 0; n < 1700; ) begin
            if ($urandom_range(0, 99) == 0) fill_bias = $urandom_range(20, 80);
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst; b++, n++) begin
                if ($urandom_range(0, 99) < fill_bias)
                    send($urandom_range(0, 1) ? mpq_pkg::OP_INSERT : mpq_pkg::OP_LOAD,
                         rand_value($urandom_range(0, 1) ? 8 : 100000));
                else
                    send($urandom_range(0, 1) ? mpq_pkg::OP_POP : mpq_pkg::OP_PEEK,
                         $urandom);
            end
            if ($urandom_range(0, 3) != 0) gap();
        end
        i_in_valid <= 1'b0;
        i_in       <= '0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
